### src/conv2d_valid_stream_top_defines.svh
// Assertion macros shared by the conv2d valid stream RTL.
`ifndef CONV2D_VALID_STREAM_TOP_DEFINES_SVH
`define CONV2D_VALID_STREAM_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CVS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CVS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/cvs_pkg.sv
// Shared types and constants for the conv2d valid stream block.
package cvs_pkg;

   // Default sizing of the top level.
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_MAX_KERNEL = 5;

   // Field widths.
   localparam int PIX_W        = 16;
   localparam int COEF_W       = 16;
   localparam int SUM_W        = 40;
   localparam int OUT_COL_W    = 10;
   localparam int OUT_ROW_W    = 12;
   localparam int CIDX_FIELD_W = 5;
   localparam int IMG_W_W      = 11;
   localparam int IMG_H_W      = 13;
   localparam int KDIM_FIELD_W = 3;
   localparam int CSR_DATA_W   = 13;

   // Register reset values.
   localparam int RST_IMAGE_WIDTH   = 5;
   localparam int RST_IMAGE_HEIGHT  = 5;
   localparam int RST_KERNEL_WIDTH  = 3;
   localparam int RST_KERNEL_HEIGHT = 3;

   // Input word kinds.
   localparam logic KIND_COEF  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_KERNEL_WIDTH  = 2'd2,
      CSR_KERNEL_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                       kind;
      logic [CIDX_FIELD_W-1:0]    coef_index;
      logic signed [COEF_W-1:0]   coef_value;
      logic signed [PIX_W-1:0]    pixel_value;
   } req_data_type;

   typedef struct packed {
      logic signed [SUM_W-1:0]    sum;
      logic [OUT_COL_W-1:0]       out_col;
      logic [OUT_ROW_W-1:0]       out_row;
      logic                       frame_last;
   } rsp_data_type;

endpackage

### src/cvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cvs_ram #(
   parameter int WIDTH = cvs_pkg::PIX_W,
   parameter int DEPTH = cvs_pkg::DEF_MAX_WIDTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/conv2d_valid_stream_top.sv
// Top level of the streaming valid-mode 2D convolution block.
// Streaming valid-mode 2D cross-correlation. Load kernel coefficients with kind-0
// words (row-major index, current kernel width), then send pixels in raster order
// with kind-1 words. Each pixel that completes a kernel window gives one result
// word with the full-precision sum, the window's left column and top row, and a
// last flag on the frame's final window. The block takes one word per clock,
// coefficient or pixel, while the output skid is empty; a result passes stages 1
// to 4 and then the output register. That rate is set by the line store: one
// RAM holds one column of the last MAX_KERNEL rows per word, and each pixel does
// one read-modify-write of its column (read at accept, written back from stage 1,
// forwarded when the next pixel hits the same column). The line store has no
// clearing pass: window rows that no pixel has written since power-up give
// undefined sums. Register values of zero read as one and values above the
// maximum saturate; write registers only while the block is idle.
`include "conv2d_valid_stream_top_defines.svh"

module conv2d_valid_stream_top #(
   parameter int MAX_WIDTH  = cvs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cvs_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = cvs_pkg::DEF_MAX_KERNEL
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cvs_pkg::req_data_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cvs_pkg::rsp_data_type             rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  cvs_pkg::csr_index_type            csr_index,
   input  logic [cvs_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int PIX_W      = cvs_pkg::PIX_W;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CCNT_W     = COL_W + 1;
   localparam int RCNT_W     = ROW_W + 1;
   localparam int KDIM_W     = $clog2(MAX_KERNEL + 1);
   localparam int SLOT_W     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
   localparam int CIDX_W     = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int IDX_EXT_W  = (CIDX_W > cvs_pkg::CIDX_FIELD_W) ? CIDX_W
                                                               : cvs_pkg::CIDX_FIELD_W;
   localparam int PROD_W     = 2 * PIX_W;
   localparam int ROWSUM_W   = PROD_W + $clog2(MAX_KERNEL + 1);
   localparam int ACC_W      = ROWSUM_W + $clog2(MAX_KERNEL + 1);
   localparam int WORD_W     = MAX_KERNEL * PIX_W;

   // Configuration registers and clamped values
   logic [cvs_pkg::IMG_W_W-1:0]      image_width_ff;
   logic [cvs_pkg::IMG_H_W-1:0]      image_height_ff;
   logic [cvs_pkg::KDIM_FIELD_W-1:0] kernel_width_ff;
   logic [cvs_pkg::KDIM_FIELD_W-1:0] kernel_height_ff;
   logic [CCNT_W-1:0]                w_eff;
   logic [RCNT_W-1:0]                h_eff;
   logic [KDIM_W-1:0]                kw_eff;
   logic [KDIM_W-1:0]                kh_eff;

   // Stage 0: accept and position counters
   logic                advance;
   logic                accept;
   logic                pix_accept;
   logic [COL_W-1:0]    col_count_ff;
   logic [ROW_W-1:0]    row_count_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [CCNT_W-1:0]   c_next;
   logic [RCNT_W-1:0]   r_next;
   logic                win_full;
   logic                row_end;
   logic                frame_end;
   logic [COL_W-1:0]    left;
   logic [ROW_W-1:0]    top;

   // Stage 1: line store read-modify-write, window shift, coefficient select
   logic                             s1_valid_ff;
   logic                             s1_pixel_ff;
   logic                             s1_emit_ff;
   logic [COL_W-1:0]                 s1_addr_ff;
   logic [SLOT_W-1:0]                s1_slot_ff;
   logic signed [PIX_W-1:0]          s1_pix_ff;
   logic [cvs_pkg::CIDX_FIELD_W-1:0] s1_cidx_ff;
   logic signed [cvs_pkg::COEF_W-1:0] s1_cval_ff;
   logic [cvs_pkg::OUT_COL_W-1:0]    s1_col_ff;
   logic [cvs_pkg::OUT_ROW_W-1:0]    s1_row_ff;
   logic                             s1_last_ff;
   logic [IDX_EXT_W-1:0]             cidx_ext;

   logic                                 ram_we;
   logic                                 ram_re;
   logic [WORD_W-1:0]                    ram_rdata;
   logic [MAX_KERNEL-1:0][PIX_W-1:0]     base_word;
   logic [MAX_KERNEL-1:0][PIX_W-1:0]     merged;
   logic signed [PIX_W-1:0]              col_new [MAX_KERNEL];
   logic                                 fwd_valid_ff;
   logic [COL_W-1:0]                     fwd_addr_ff;
   logic [MAX_KERNEL-1:0][PIX_W-1:0]     fwd_data_ff;

   logic signed [cvs_pkg::COEF_W-1:0] coef_ff     [COEF_DEPTH];
   logic signed [cvs_pkg::COEF_W-1:0] coef_sel_in [MAX_KERNEL][MAX_KERNEL];
   logic                              tap_on_in   [MAX_KERNEL][MAX_KERNEL];

   // Stage 2: window and selected coefficients
   logic                              s2_valid_ff;
   logic signed [PIX_W-1:0]           win_ff      [MAX_KERNEL][MAX_KERNEL];
   logic signed [cvs_pkg::COEF_W-1:0] coef_sel_ff [MAX_KERNEL][MAX_KERNEL];
   logic                              tap_on_ff   [MAX_KERNEL][MAX_KERNEL];
   logic [cvs_pkg::OUT_COL_W-1:0]     s2_col_ff;
   logic [cvs_pkg::OUT_ROW_W-1:0]     s2_row_ff;
   logic                              s2_last_ff;

   // Stage 3: products
   logic                          s3_valid_ff;
   logic signed [PROD_W-1:0]      prod_ff [MAX_KERNEL][MAX_KERNEL];
   logic [cvs_pkg::OUT_COL_W-1:0] s3_col_ff;
   logic [cvs_pkg::OUT_ROW_W-1:0] s3_row_ff;
   logic                          s3_last_ff;

   // Stage 4: row sums
   logic                          s4_valid_ff;
   logic signed [ROWSUM_W-1:0]    rsum_in [MAX_KERNEL];
   logic signed [ROWSUM_W-1:0]    rsum_ff [MAX_KERNEL];
   logic [cvs_pkg::OUT_COL_W-1:0] s4_col_ff;
   logic [cvs_pkg::OUT_ROW_W-1:0] s4_row_ff;
   logic                          s4_last_ff;
   logic signed [ACC_W-1:0]       acc;

   // Output register and skid
   logic                  push;
   logic                  pop;
   cvs_pkg::rsp_data_type new_word;
   logic                  rsp_valid_ff;
   cvs_pkg::rsp_data_type rsp_data_ff;
   logic                  skid_valid_ff;
   cvs_pkg::rsp_data_type skid_data_ff;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= cvs_pkg::IMG_W_W'(cvs_pkg::RST_IMAGE_WIDTH);
         image_height_ff  <= cvs_pkg::IMG_H_W'(cvs_pkg::RST_IMAGE_HEIGHT);
         kernel_width_ff  <= cvs_pkg::KDIM_FIELD_W'(cvs_pkg::RST_KERNEL_WIDTH);
         kernel_height_ff <= cvs_pkg::KDIM_FIELD_W'(cvs_pkg::RST_KERNEL_HEIGHT);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cvs_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_data[cvs_pkg::IMG_W_W-1:0];
            end
            cvs_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_data[cvs_pkg::IMG_H_W-1:0];
            end
            cvs_pkg::CSR_KERNEL_WIDTH: begin
               kernel_width_ff <= csr_data[cvs_pkg::KDIM_FIELD_W-1:0];
            end
            cvs_pkg::CSR_KERNEL_HEIGHT: begin
               kernel_height_ff <= csr_data[cvs_pkg::KDIM_FIELD_W-1:0];
            end
         endcase
      end
   end

   // Clamp registers to 1..max
   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = CCNT_W'(1);
      end else if (int'(image_width_ff) > MAX_WIDTH) begin
         w_eff = CCNT_W'(MAX_WIDTH);
      end else begin
         w_eff = CCNT_W'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         h_eff = RCNT_W'(1);
      end else if (int'(image_height_ff) > MAX_HEIGHT) begin
         h_eff = RCNT_W'(MAX_HEIGHT);
      end else begin
         h_eff = RCNT_W'(image_height_ff);
      end
      if (kernel_width_ff == '0) begin
         kw_eff = KDIM_W'(1);
      end else if (int'(kernel_width_ff) > MAX_KERNEL) begin
         kw_eff = KDIM_W'(MAX_KERNEL);
      end else begin
         kw_eff = KDIM_W'(kernel_width_ff);
      end
      if (kernel_height_ff == '0) begin
         kh_eff = KDIM_W'(1);
      end else if (int'(kernel_height_ff) > MAX_KERNEL) begin
         kh_eff = KDIM_W'(MAX_KERNEL);
      end else begin
         kh_eff = KDIM_W'(kernel_height_ff);
      end
   end

   // Whole pipeline moves unless the skid holds a word
   assign advance    = !skid_valid_ff;
   assign req_ready  = advance;
   assign accept     = req_valid && req_ready;
   assign pix_accept = accept && (req_data.kind == cvs_pkg::KIND_PIXEL);

   // Window position of the incoming pixel
   assign c_next    = CCNT_W'(col_count_ff) + CCNT_W'(1);
   assign r_next    = RCNT_W'(row_count_ff) + RCNT_W'(1);
   assign win_full  = (c_next >= CCNT_W'(kw_eff)) && (r_next >= RCNT_W'(kh_eff));
   assign row_end   = (c_next >= w_eff);
   assign frame_end = (r_next >= h_eff);
   assign left      = COL_W'(c_next - CCNT_W'(kw_eff));
   assign top       = ROW_W'(r_next - RCNT_W'(kh_eff));

   // Advance column, row and row slot after each pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         slot_ff      <= '0;
      end else if (pix_accept) begin
         if (row_end) begin
            col_count_ff <= '0;
            if (frame_end) begin
               row_count_ff <= '0;
               slot_ff      <= '0;
            end else begin
               row_count_ff <= r_next[ROW_W-1:0];
               if (int'(slot_ff) == MAX_KERNEL - 1) begin
                  slot_ff <= '0;
               end else begin
                  slot_ff <= slot_ff + SLOT_W'(1);
               end
            end
         end else begin
            col_count_ff <= c_next[COL_W-1:0];
         end
      end
   end

   // Stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= (req_data.kind == cvs_pkg::KIND_PIXEL);
         s1_emit_ff  <= win_full;
         s1_addr_ff  <= col_count_ff;
         s1_slot_ff  <= slot_ff;
         s1_pix_ff   <= req_data.pixel_value;
         s1_cidx_ff  <= req_data.coef_index;
         s1_cval_ff  <= req_data.coef_value;
         s1_col_ff   <= cvs_pkg::OUT_COL_W'(left);
         s1_row_ff   <= cvs_pkg::OUT_ROW_W'(top);
         s1_last_ff  <= row_end && frame_end;
      end
   end

   // Line store: one column of MAX_KERNEL row slots per word
   assign ram_re = pix_accept;
   assign ram_we = advance && s1_valid_ff && s1_pixel_ff;

   cvs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr_ff),
      .wr_data (merged),
      .rd_en   (ram_re),
      .rd_addr (col_count_ff),
      .rd_data (ram_rdata)
   );

   // Forward the previous write, merge the pixel, build the new column
   always_comb begin
      int sel;
      sel = 0;
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         base_word = fwd_data_ff;
      end else begin
         base_word = ram_rdata;
      end
      merged             = base_word;
      merged[s1_slot_ff] = s1_pix_ff;
      col_new[0]         = s1_pix_ff;
      for (int d = 1; d < MAX_KERNEL; d++) begin
         if (int'(s1_slot_ff) >= d) begin
            sel = int'(s1_slot_ff) - d;
         end else begin
            sel = int'(s1_slot_ff) + MAX_KERNEL - d;
         end
         col_new[d] = base_word[sel[SLOT_W-1:0]];
      end
   end

   // Hold the last write for a read of the same column in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (advance) begin
         fwd_valid_ff <= ram_we;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= merged;
      end
   end

   // Coefficient loads take effect in stage-1 order
   assign cidx_ext = IDX_EXT_W'(s1_cidx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_DEPTH; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (advance && s1_valid_ff && !s1_pixel_ff
                   && (cidx_ext < IDX_EXT_W'(COEF_DEPTH))) begin
         coef_ff[cidx_ext[CIDX_W-1:0]] <= s1_cval_ff;
      end
   end

   // Map window taps to kernel positions; drop taps outside the kernel
   always_comb begin
      int ky;
      int kx;
      int idx;
      ky  = 0;
      kx  = 0;
      idx = 0;
      for (int d = 0; d < MAX_KERNEL; d++) begin
         for (int j = 0; j < MAX_KERNEL; j++) begin
            ky  = int'(kh_eff) - 1 - d;
            kx  = int'(kw_eff) - 1 - j;
            idx = ky * int'(kw_eff) + kx;
            tap_on_in[d][j] = (ky >= 0) && (kx >= 0);
            if (tap_on_in[d][j]) begin
               coef_sel_in[d][j] = coef_ff[idx[CIDX_W-1:0]];
            end else begin
               coef_sel_in[d][j] = '0;
            end
         end
      end
   end

   // Stage 2 control and window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         for (int d = 0; d < MAX_KERNEL; d++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
               win_ff[d][j] <= '0;
            end
         end
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_pixel_ff && s1_emit_ff;
         if (s1_valid_ff && s1_pixel_ff) begin
            for (int d = 0; d < MAX_KERNEL; d++) begin
               for (int j = MAX_KERNEL - 1; j > 0; j--) begin
                  win_ff[d][j] <= win_ff[d][j-1];
               end
               win_ff[d][0] <= col_new[d];
            end
         end
      end
   end

   // Stage 2 payload
   always_ff @(posedge clock) begin
      if (advance) begin
         coef_sel_ff <= coef_sel_in;
         tap_on_ff   <= tap_on_in;
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // Stage 3: one multiplier per tap
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int d = 0; d < MAX_KERNEL; d++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
               if (tap_on_ff[d][j]) begin
                  prod_ff[d][j] <= win_ff[d][j] * coef_sel_ff[d][j];
               end else begin
                  prod_ff[d][j] <= '0;
               end
            end
         end
         s3_col_ff  <= s2_col_ff;
         s3_row_ff  <= s2_row_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // Stage 4: sum each window row
   always_comb begin
      for (int d = 0; d < MAX_KERNEL; d++) begin
         rsum_in[d] = '0;
         for (int j = 0; j < MAX_KERNEL; j++) begin
            rsum_in[d] = rsum_in[d] + ROWSUM_W'(prod_ff[d][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsum_ff    <= rsum_in;
         s4_col_ff  <= s3_col_ff;
         s4_row_ff  <= s3_row_ff;
         s4_last_ff <= s3_last_ff;
      end
   end

   // Final sum across rows
   always_comb begin
      acc = '0;
      for (int d = 0; d < MAX_KERNEL; d++) begin
         acc = acc + ACC_W'(rsum_ff[d]);
      end
      new_word.sum        = cvs_pkg::SUM_W'(acc);
      new_word.out_col    = s4_col_ff;
      new_word.out_row    = s4_row_ff;
      new_word.frame_last = s4_last_ff;
   end

   // Output register with skid
   assign push = s4_valid_ff && advance;
   assign pop  = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (rsp_valid_ff && !rsp_ready) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (rsp_valid_ff && !rsp_ready) begin
            skid_data_ff <= new_word;
         end else begin
            rsp_data_ff <= new_word;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CVS_ASSERT_IMP(a_skid_behind_out, skid_valid_ff, rsp_valid_ff, "skid full with empty output")
   `CVS_ASSERT_IMP(a_skid_fill_cause, $rose(skid_valid_ff), $past(rsp_valid_ff && !rsp_ready), "skid filled without stall")
   `CVS_ASSERT_NXT(a_fwd_capture, ram_we && ram_re && (s1_addr_ff == col_count_ff), fwd_valid_ff && (fwd_addr_ff == s1_addr_ff), "column write not forwarded")
   `CVS_ASSERT_NXT(a_coef_no_result, advance && s1_valid_ff && !s1_pixel_ff, !s2_valid_ff, "coefficient word made a result")
   `CVS_ASSERT_IMP(a_col_bound, 1'b1, int'(col_count_ff) < MAX_WIDTH, "column counter out of range")

endmodule

### sim/testbench.sv
// Self-checking testbench for the streaming valid-mode 2D convolution block.
module testbench;
   import cvs_pkg::*;

   localparam int COEF_SLOTS     = DEF_MAX_KERNEL * DEF_MAX_KERNEL;
   localparam int RANDOM_ITEMS   = 1360;
   localparam int SETTLE_CYCLES  = 12;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int MAX_REPORTS    = 10;
   localparam int HOLDOFF_AT     = 32;
   localparam int HOLDOFF_CYCLES = 400;

   typedef enum logic [1:0] {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic          clock;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_data_type  req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_data_type  rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Words waiting for the driver and window sums waiting for the block.
   // A window that reads a never-written line store entry has an unknown sum;
   // only its position and last flag are checked.
   req_data_type conv_words_q[$];
   rsp_data_type sums_due[$];
   bit           sum_known_q[$];
   int words_pushed = 0;
   int words_taken  = 0;
   int fail_count   = 0;
   int cycle_count  = 0;

   // Predicted block state: registers, kernel, line store and raster position.
   logic [IMG_W_W-1:0]      img_w_reg;
   logic [IMG_H_W-1:0]      img_h_reg;
   logic [KDIM_FIELD_W-1:0] ker_w_reg;
   logic [KDIM_FIELD_W-1:0] ker_h_reg;
   logic signed [COEF_W-1:0] coef_mem [COEF_SLOTS];
   logic signed [PIX_W-1:0]  line_mem [DEF_MAX_KERNEL][DEF_MAX_WIDTH];
   bit                       line_set [DEF_MAX_KERNEL][DEF_MAX_WIDTH];
   int unsigned col_cnt;
   int unsigned row_cnt;

   // Sender burst state and receiver stall state.
   int burst_left = 0;
   int gap_left   = 0;
   rx_mode_type rx_mode = RX_STEADY;
   int mode_left     = 0;
   int hold_left     = 0;
   bit holdoff_done  = 1'b0;

   conv2d_valid_stream_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Bias samples toward the signed extremes, zero and minus one, otherwise fully random.
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 15))
         0:       pick_sample = 16'h8000;
         1:       pick_sample = 16'h7FFF;
         2:       pick_sample = 16'h0000;
         3:       pick_sample = 16'hFFFF;
         default: pick_sample = 16'($urandom);
      endcase
   endfunction

   // Apply one word to the predicted state; queue the window sum it completes.
   task automatic predict_window_sum(input req_data_type w);
      int unsigned wd, ht, kw, kh, c, r, left, top;
      longint acc;
      bit known;
      rsp_data_type res;
      if (w.kind == KIND_COEF) begin
         if (w.coef_index < COEF_SLOTS) coef_mem[w.coef_index] = w.coef_value;
      end else begin
         wd = clamp_dim(img_w_reg, DEF_MAX_WIDTH);
         ht = clamp_dim(img_h_reg, DEF_MAX_HEIGHT);
         kw = clamp_dim(ker_w_reg, DEF_MAX_KERNEL);
         kh = clamp_dim(ker_h_reg, DEF_MAX_KERNEL);
         c = col_cnt;
         r = row_cnt;
         line_mem[r % DEF_MAX_KERNEL][c % DEF_MAX_WIDTH] = w.pixel_value;
         line_set[r % DEF_MAX_KERNEL][c % DEF_MAX_WIDTH] = 1'b1;
         if (c + 1 >= kw && r + 1 >= kh) begin
            left  = c + 1 - kw;
            top   = r + 1 - kh;
            acc   = 0;
            known = 1'b1;
            for (int ky = 0; ky < kh; ky++) begin
               for (int kx = 0; kx < kw; kx++) begin
                  if (!line_set[(top + ky) % DEF_MAX_KERNEL][(left + kx) % DEF_MAX_WIDTH])
                     known = 1'b0;
                  acc += longint'(line_mem[(top + ky) % DEF_MAX_KERNEL]
                                          [(left + kx) % DEF_MAX_WIDTH])
                       * longint'(coef_mem[(ky * kw + kx) % COEF_SLOTS]);
               end
            end
            res.sum        = acc[SUM_W-1:0];
            res.out_col    = left[OUT_COL_W-1:0];
            res.out_row    = top[OUT_ROW_W-1:0];
            res.frame_last = (c + 1 >= wd && r + 1 >= ht);
            sums_due.push_back(res);
            sum_known_q.push_back(known);
         end
         // Advance the raster position, wrapping at row and frame end.
         if (c + 1 >= wd) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= ht) ? 0 : r + 1;
         end else begin
            col_cnt = c + 1;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input rsp_data_type want,
                                  input rsp_data_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%s: expected sum=%0d col=%0d row=%0d last=%0b, got sum=%0d col=%0d row=%0d last=%0b",
                  what, want.sum, want.out_col, want.out_row, want.frame_last,
                  got.sum, got.out_col, got.out_row, got.frame_last);
   endtask

   task automatic push_coef(input int unsigned idx, input logic [15:0] value);
      req_data_type w;
      w.kind        = KIND_COEF;
      w.coef_index  = idx[CIDX_FIELD_W-1:0];
      w.coef_value  = value;
      w.pixel_value = 16'($urandom);
      conv_words_q.push_back(w);
      words_pushed++;
   endtask

   task automatic push_pixel(input logic [15:0] value);
      req_data_type w;
      w.kind        = KIND_PIXEL;
      w.coef_index  = 5'($urandom);
      w.coef_value  = 16'($urandom);
      w.pixel_value = value;
      conv_words_q.push_back(w);
      words_pushed++;
   endtask

   // Hold one register write until the block takes it.
   task automatic write_reg(input csr_index_type which, input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Wait until every word is taken and every sum is back, then let the pipe drain.
   task automatic wait_idle();
      while (words_taken != words_pushed || sums_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: offer words in bursts with random gaps; hold a word until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (conv_words_q.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= conv_words_q.pop_front();
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 32);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall on a changing pattern, with one long hold-off under load.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!holdoff_done && words_taken >= HOLDOFF_AT) begin
            hold_left    = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STEADY: rsp_ready <= 1'b1;
               RX_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Monitor: track register writes, predict taken words, check returned sums.
   always @(posedge clock) begin
      rsp_data_type want;
      bit want_known;
      if (reset) begin
         img_w_reg = RST_IMAGE_WIDTH;
         img_h_reg = RST_IMAGE_HEIGHT;
         ker_w_reg = RST_KERNEL_WIDTH;
         ker_h_reg = RST_KERNEL_HEIGHT;
         col_cnt   = 0;
         row_cnt   = 0;
         for (int i = 0; i < COEF_SLOTS; i++) coef_mem[i] = '0;
         for (int i = 0; i < DEF_MAX_KERNEL; i++)
            for (int j = 0; j < DEF_MAX_WIDTH; j++) begin
               line_mem[i][j] = '0;
               line_set[i][j] = 1'b0;
            end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   img_w_reg = csr_data[IMG_W_W-1:0];
               CSR_IMAGE_HEIGHT:  img_h_reg = csr_data[IMG_H_W-1:0];
               CSR_KERNEL_WIDTH:  ker_w_reg = csr_data[KDIM_FIELD_W-1:0];
               CSR_KERNEL_HEIGHT: ker_h_reg = csr_data[KDIM_FIELD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_window_sum(req_data);
            words_taken <= words_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (sums_due.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_data);
            end else begin
               want       = sums_due.pop_front();
               want_known = sum_known_q.pop_front();
               if ((want_known && rsp_data.sum !== want.sum) ||
                   rsp_data.out_col !== want.out_col ||
                   rsp_data.out_row !== want.out_row ||
                   rsp_data.frame_last !== want.frame_last)
                  report_mismatch("result mismatch", want, rsp_data);
            end
         end
      end
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("conv2d_valid_stream_top test failed");
         $finish;
      end
   end

   initial begin
      int random_items;
      int n_pix;
      int drain_wait;
      int unsigned reg_val;
      random_items = 0;
      drain_wait   = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: one 3x3 frame under the reset 3x3 kernel, extreme values,
      // loads to ignored indexes.
      write_reg(CSR_IMAGE_WIDTH, 3);
      write_reg(CSR_IMAGE_HEIGHT, 3);
      push_coef(0, 16'h8000);
      push_coef(2, 16'h7FFF);
      push_coef(4, 16'h7FFF);
      push_coef(8, 16'h8000);
      push_coef(25, 16'h1234);
      push_coef(31, 16'h7FFF);
      push_pixel(16'h7FFF);
      push_pixel(16'h8000);
      push_pixel(16'h8000);
      push_pixel(16'h0001);
      push_pixel(16'hFFFF);
      push_pixel(16'h0000);
      push_pixel(16'h7FFF);
      push_pixel(16'h5555);
      push_pixel(16'h8000);
      wait_idle();

      // Directed: kernel wider than the image gives no results.
      write_reg(CSR_KERNEL_WIDTH, 5);
      for (int i = 0; i < 9; i++) push_pixel(pick_sample());
      wait_idle();

      // Directed: 1x1 kernel on an 8x8 frame gives one result per pixel, so the
      // long receiver hold-off that starts here backs the block up.
      write_reg(CSR_IMAGE_WIDTH, 8);
      write_reg(CSR_IMAGE_HEIGHT, 8);
      write_reg(CSR_KERNEL_WIDTH, 1);
      write_reg(CSR_KERNEL_HEIGHT, 1);
      push_coef(0, pick_sample());
      for (int i = 0; i < 64; i++) push_pixel(pick_sample());
      wait_idle();

      // Random phases: new sizes, kernel reloads, pixel runs with stray loads.
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 9))
                  0:       reg_val = 0;
                  1:       reg_val = 1;
                  2:       reg_val = DEF_MAX_WIDTH;
                  3:       reg_val = $urandom_range(DEF_MAX_WIDTH + 1, 2047);
                  default: reg_val = $urandom_range(2, 12);
               endcase
               write_reg(CSR_IMAGE_WIDTH, reg_val);
            end
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 9))
                  0:       reg_val = 0;
                  1:       reg_val = 1;
                  2:       reg_val = DEF_MAX_HEIGHT;
                  3:       reg_val = $urandom_range(DEF_MAX_HEIGHT + 1, 8191);
                  default: reg_val = $urandom_range(2, 10);
               endcase
               write_reg(CSR_IMAGE_HEIGHT, reg_val);
            end
            if ($urandom_range(0, 1) == 1) write_reg(CSR_KERNEL_WIDTH, $urandom_range(0, 7));
            if ($urandom_range(0, 1) == 1) write_reg(CSR_KERNEL_HEIGHT, $urandom_range(0, 7));
         end
         if ($urandom_range(0, 1) == 1) begin
            for (int i = 0; i < COEF_SLOTS; i++) push_coef(i, pick_sample());
            random_items += COEF_SLOTS;
         end
         n_pix = $urandom_range(8, 120);
         for (int i = 0; i < n_pix; i++) begin
            if ($urandom_range(0, 19) == 0) begin
               push_coef($urandom_range(0, 31), pick_sample());
               random_items++;
            end
            push_pixel(pick_sample());
         end
         random_items += n_pix;
         wait_idle();
      end

      // Drain with a bound, then count anything still owed.
      while ((words_taken != words_pushed || sums_due.size() != 0) &&
             drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sums_due.size() != 0) begin
         $display("results never returned: %0d", sums_due.size());
         fail_count += sums_due.size();
      end
      if (fail_count == 0)
         $display("conv2d_valid_stream_top test passed");
      else
         $display("conv2d_valid_stream_top test failed");
      $finish;
   end

endmodule
